// ----- rtl/vn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared constants and a hash helper for the 2D value noise unit.
// ----------------------------------------------------------------------------
package vn2d_pkg;

  localparam int COORD_W       = 32;
  localparam int VALUE_W       = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int HASH_SHIFT    = 13;

  localparam logic [COORD_W-1:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [COORD_W-1:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [COORD_W-1:0] HASH_MUL_MIX = 32'd1274126177;

  // Xor-shift fold of a corner sum; only the low value bits matter afterwards.
  function automatic logic [VALUE_W-1:0] hash_fold(input logic [COORD_W-1:0] h);
    logic [COORD_W-1:0] m;
    m = h ^ (h >> HASH_SHIFT);
    return m[VALUE_W-1:0];
  endfunction

endpackage

// ----- rtl/vn2d_in_if.sv -----
// ----------------------------------------------------------------------------
// vn2d_in_if
// Coordinate channel: one word carries a signed fixed-point x and y.
// ----------------------------------------------------------------------------
interface vn2d_in_if import vn2d_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

// ----- rtl/vn2d_out_if.sv -----
// ----------------------------------------------------------------------------
// vn2d_out_if
// Result channel: one word carries an unsigned Q0.24 noise value.
// ----------------------------------------------------------------------------
interface vn2d_out_if import vn2d_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

// ----- rtl/vn2d_blend.sv -----
// ----------------------------------------------------------------------------
// vn2d_blend
// Linear blend between two Q0.24 values with a weight of FRAC_BITS fraction
// bits. The scaled difference is truncated toward the first value.
// ----------------------------------------------------------------------------
module vn2d_blend import vn2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [VALUE_W-1:0]   a,
  input  logic [VALUE_W-1:0]   b,
  input  logic [FRAC_BITS-1:0] w,
  output logic [VALUE_W-1:0]   r
);

  localparam int PW = VALUE_W + FRAC_BITS;

  logic               up;
  logic [VALUE_W-1:0] diff;
  logic [PW-1:0]      prod;
  logic [VALUE_W-1:0] delta;

  assign up    = (b >= a);
  assign diff  = up ? (b - a) : (a - b);
  assign prod  = PW'(w) * PW'(diff);
  assign delta = prod[PW-1:FRAC_BITS];
  assign r     = up ? (a + delta) : (a - delta);

endmodule

// ----- rtl/value_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// value_noise_2d_unit
// Each of the five register stages holds a valid bit and advances whenever
// the stage after it is empty or moving, so a coordinate word passes stages
// 1 to 5 in order. Throughput: one word per cycle unless the output stalls.
// Reset: synchronous, active low; clears every stage valid bit.
// Two-dimensional value noise with hashed lattice corners, smoothstep
// weights and bilinear interpolation.
// ----------------------------------------------------------------------------
module value_noise_2d_unit import vn2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vn2d_in_if.sink   in_ch,
  vn2d_out_if.source out_ch
);

  localparam int FW = FRAC_BITS;

  // Stage 1: lattice products and squared fractions.
  logic               v1_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic [FW-1:0]      tx_r, ty_r, t2x_r, t2y_r;
  // Stage 2: folded corner hashes and smoothstep weights.
  logic               v2_r;
  logic [VALUE_W-1:0] g00_r, g10_r, g01_r, g11_r;
  logic [FW-1:0]      u2_r, w2_r;
  // Stage 3: corner values.
  logic               v3_r;
  logic [VALUE_W-1:0] c00_r, c10_r, c01_r, c11_r;
  logic [FW-1:0]      u3_r, w3_r;
  // Stage 4: blends along x.
  logic               v4_r;
  logic [VALUE_W-1:0] nx0_r, nx1_r;
  logic [FW-1:0]      w4_r;
  // Stage 5: output register.
  logic               out_vld_r;
  logic [VALUE_W-1:0] out_data_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_vld_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready        = rdy1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.noise_value = out_data_r;

  logic [COORD_W-1:0] ix, iy;
  logic [FW-1:0]      fx, fy;
  logic [2*FW-1:0]    sqx, sqy;

  assign ix  = COORD_W'($signed(in_ch.coord_x) >>> FW);
  assign iy  = COORD_W'($signed(in_ch.coord_y) >>> FW);
  assign fx  = in_ch.coord_x[FW-1:0];
  assign fy  = in_ch.coord_y[FW-1:0];
  assign sqx = (2*FW)'(fx) * (2*FW)'(fx);
  assign sqy = (2*FW)'(fy) * (2*FW)'(fy);

  logic [FW+1:0]      kx, ky;
  logic [2*FW+1:0]    smx, smy;
  logic [COORD_W-1:0] h00, h10, h01, h11;

  assign kx  = {2'b11, {FW{1'b0}}} - {1'b0, tx_r, 1'b0};
  assign ky  = {2'b11, {FW{1'b0}}} - {1'b0, ty_r, 1'b0};
  assign smx = (2*FW+2)'(t2x_r) * (2*FW+2)'(kx);
  assign smy = (2*FW+2)'(t2y_r) * (2*FW+2)'(ky);
  assign h00 = px_r + py_r;
  assign h10 = px_r + HASH_MUL_X + py_r;
  assign h01 = px_r + py_r + HASH_MUL_Y;
  assign h11 = px_r + HASH_MUL_X + py_r + HASH_MUL_Y;

  logic [VALUE_W-1:0] mix_k;
  assign mix_k = HASH_MUL_MIX[VALUE_W-1:0];

  logic [VALUE_W-1:0] nx0, nx1, res;

  vn2d_blend #(.FRAC_BITS(FW)) u_blend_x0 (.a(c00_r), .b(c10_r), .w(u3_r), .r(nx0));
  vn2d_blend #(.FRAC_BITS(FW)) u_blend_x1 (.a(c01_r), .b(c11_r), .w(u3_r), .r(nx1));
  vn2d_blend #(.FRAC_BITS(FW)) u_blend_y  (.a(nx0_r), .b(nx1_r), .w(w4_r), .r(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_vld_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      px_r  <= COORD_W'(ix * HASH_MUL_X);
      py_r  <= COORD_W'(iy * HASH_MUL_Y);
      tx_r  <= fx;
      ty_r  <= fy;
      t2x_r <= sqx[2*FW-1:FW];
      t2y_r <= sqy[2*FW-1:FW];
    end
    if (rdy2 && v1_r) begin
      g00_r <= hash_fold(h00);
      g10_r <= hash_fold(h10);
      g01_r <= hash_fold(h01);
      g11_r <= hash_fold(h11);
      u2_r  <= smx[2*FW-1:FW];
      w2_r  <= smy[2*FW-1:FW];
    end
    if (rdy3 && v2_r) begin
      c00_r <= VALUE_W'(g00_r * mix_k);
      c10_r <= VALUE_W'(g10_r * mix_k);
      c01_r <= VALUE_W'(g01_r * mix_k);
      c11_r <= VALUE_W'(g11_r * mix_k);
      u3_r  <= u2_r;
      w3_r  <= w2_r;
    end
    if (rdy4 && v3_r) begin
      nx0_r <= nx0;
      nx1_r <= nx1;
      w4_r  <= w3_r;
    end
    if (rdy5 && v4_r) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- tb/sv/value_noise_2d_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_unit_tb
// Drives coordinate words through the noise unit in random bursts while the
// result side stalls on its own pattern. Every result word is checked against
// a fixed-point noise prediction made when its coordinate word is accepted.
// ----------------------------------------------------------------------------
module value_noise_2d_unit_tb import vn2d_pkg::*; ();

  localparam int FB         = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_WORDS = 1930;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_word_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_EVERY_THIRD
  } sink_mode_t;

  logic clk;
  logic rst_n;

  vn2d_in_if  in_if();
  vn2d_out_if out_if();

  value_noise_2d_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  coord_word_t        coord_pending[$];
  logic [VALUE_W-1:0] noise_expected[$];
  int                 err_cnt     = 0;
  int                 idle_cycles = 0;
  int                 burst_left  = 1;
  int                 gap_left    = 0;
  int                 mode_left   = 0;
  int                 phase_cnt   = 0;
  sink_mode_t         sink_mode   = RDY_ALWAYS;

  function automatic logic [VALUE_W-1:0] lattice_hash(logic [COORD_W-1:0] ix,
                                                      logic [COORD_W-1:0] iy);
    logic [COORD_W-1:0] h;
    h = ix * HASH_MUL_X + iy * HASH_MUL_Y;
    h = (h ^ (h >> HASH_SHIFT)) * HASH_MUL_MIX;
    return h[VALUE_W-1:0];
  endfunction

  function automatic logic [FB-1:0] fade_weight(logic [FB-1:0] t);
    logic [63:0] tw;
    logic [63:0] t2;
    logic [63:0] k;
    logic [63:0] s;
    tw = 64'(t);
    t2 = (tw * tw) >> FB;
    k  = (64'd3 << FB) - 64'd2 * tw;
    s  = (t2 * k) >> FB;
    return s[FB-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] mix_toward(logic [VALUE_W-1:0] a,
                                                    logic [VALUE_W-1:0] b,
                                                    logic [FB-1:0] w);
    logic [63:0] aw;
    logic [63:0] bw;
    logic [63:0] d;
    aw = 64'(a);
    bw = 64'(b);
    if (bw >= aw) begin
      d = (64'(w) * (bw - aw)) >> FB;
      return a + d[VALUE_W-1:0];
    end
    d = (64'(w) * (aw - bw)) >> FB;
    return a - d[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] noise_at(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    logic [COORD_W-1:0] ix;
    logic [COORD_W-1:0] iy;
    logic [FB-1:0]      u;
    logic [FB-1:0]      v;
    logic [VALUE_W-1:0] nx0;
    logic [VALUE_W-1:0] nx1;
    ix  = COORD_W'($signed(x) >>> FB);
    iy  = COORD_W'($signed(y) >>> FB);
    u   = fade_weight(x[FB-1:0]);
    v   = fade_weight(y[FB-1:0]);
    nx0 = mix_toward(lattice_hash(ix, iy), lattice_hash(ix + 1, iy), u);
    nx1 = mix_toward(lattice_hash(ix, iy + 1), lattice_hash(ix + 1, iy + 1), u);
    return mix_toward(nx0, nx1, v);
  endfunction

  task automatic push_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    coord_word_t w;
    w.x = x;
    w.y = y;
    coord_pending.push_back(w);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] c;
    logic [FB-1:0]      f;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = $urandom;
      4, 5, 6: begin
        c = COORD_W'($signed($urandom_range(0, 8)) - 4) << FB;
        c[FB-1:0] = FB'($urandom);
      end
      7: begin
        c = $urandom;
        c[FB-1:0] = '0;
      end
      default: begin
        c = $urandom;
        case ($urandom_range(0, 3))
          0: f = '0;
          1: f = '1;
          2: f = FB'($urandom_range(0, 3));
          default: f = ~FB'($urandom_range(0, 3));
        endcase
        c[FB-1:0] = f;
        if ($urandom_range(0, 3) == 0) c[COORD_W-1:FB] = $urandom_range(0, 1) ? '1 : '0;
      end
    endcase
    return c;
  endfunction

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        noise_expected.push_back(noise_at(in_if.coord_x, in_if.coord_y));
        void'(coord_pending.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (coord_pending.size() == 0) begin
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid   <= 1'b1;
          in_if.coord_x <= coord_pending[0].x;
          in_if.coord_y <= coord_pending[0].y;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (sink_mode)
        RDY_ALWAYS:  out_if.ready <= 1'b1;
        RDY_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
        RDY_MOSTLY:  out_if.ready <= ($urandom_range(0, 3) != 0);
        default:     out_if.ready <= (phase_cnt % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (noise_expected.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected noise word %06h", out_if.noise_value);
        end
      end else if (out_if.noise_value !== noise_expected[0]) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("noise mismatch: expected %06h, actual %06h",
                   noise_expected[0], out_if.noise_value);
        end
        void'(noise_expected.pop_front());
      end else begin
        void'(noise_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL value_noise_2d_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    out_if.ready  = 1'b0;

    // Lattice points, range extremes, wrap of the -1 cell and fraction edges.
    push_coord(32'h0000_0000, 32'h0000_0000);
    push_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_coord(32'h8000_0000, 32'h8000_0000);
    push_coord(32'h7FFF_FFFF, 32'h8000_0000);
    push_coord(32'h8000_0000, 32'h7FFF_FFFF);
    push_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_coord(32'hFFFF_0000, 32'h0001_0000);
    push_coord(32'h0000_8000, 32'h0000_8000);
    push_coord(32'h0000_0001, 32'h0000_FFFF);
    push_coord(32'h0000_FFFF, 32'h0000_0001);
    push_coord(32'hFFFF_8000, 32'h7FFF_8000);
    push_coord(32'h1234_0000, 32'hFEDC_0000);
    push_coord(32'h7FFF_0000, 32'h8000_0000);
    push_coord(32'hAAAA_AAAA, 32'h5555_5555);
    push_coord(32'h5555_5555, 32'hAAAA_AAAA);
    push_coord(32'hFFFF_FFFE, 32'h0000_0002);
    push_coord(32'h8000_FFFF, 32'hFFFF_0001);
    push_coord(32'h0001_4000, 32'hFFFE_C000);
    push_coord(32'h7FFF_C000, 32'h7FFF_4000);
    push_coord(32'hFFFF_0000, 32'hFFFF_0000);

    for (int i = 0; i < RAND_WORDS; i++) begin
      push_coord(pick_coord(), pick_coord());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (coord_pending.size() != 0 || noise_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && noise_expected.size() == 0) begin
      $display("PASS value_noise_2d_unit");
    end else begin
      $display("FAIL value_noise_2d_unit");
    end
    $finish;
  end

endmodule

// ----- value_noise_2d_unit.f -----
rtl/vn2d_pkg.sv
rtl/vn2d_in_if.sv
rtl/vn2d_out_if.sv
rtl/vn2d_blend.sv
rtl/value_noise_2d_unit.sv
tb/sv/value_noise_2d_unit_tb.sv
